@@ rtl/core/g711_companding_codec_assert.svh @@
// Assertion macros shared by the companding codec RTL.
// Each macro expects a clock named i_clk and an active-low reset i_rst_n in scope.
`ifndef G711_COMPANDING_CODEC_ASSERT_SVH
`define G711_COMPANDING_CODEC_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define G711C_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define G711C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/g711c_pkg.sv @@
// Shared types, constants and helper functions for the G.711 companding codec.
// No dependencies; imported by g711c_datapath, g711_companding_codec and the testbench.
`default_nettype none

package g711c_pkg;

    // Register file geometry.
    localparam int CfgAddrW = 4;
    localparam int CfgDataW = 32;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_LAW_SELECT       = 2'd0,
        REG_MU_BIAS          = 2'd1,
        REG_MU_MAX_MAGNITUDE = 2'd2
    } t_reg_idx;

    // Law codes.
    localparam logic LAW_A  = 1'b0;
    localparam logic LAW_MU = 1'b1;

    // Action codes.
    localparam logic ACT_COMPRESS = 1'b0;
    localparam logic ACT_EXPAND   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0]  MU_BIAS_RESET = 8'd33;
    localparam logic [12:0] MU_MAX_RESET  = 13'd8191;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic        law_select;
        logic [7:0]  mu_bias;
        logic [12:0] mu_max_magnitude;
    } t_cfg;

    // Position of the leading one of a 13-bit value (0 when the value is 0).
    function automatic logic [3:0] lead_pos(input logic [12:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 13; i++) begin
            if (v[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/g711_companding_codec.sv @@
// Top level of the G.711 A-law / mu-law companding codec.
// Depends on g711c_pkg, g711c_datapath and g711_companding_codec_assert.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction per sample:
//   i_action selects compress (i_pcm_sample to o_code_out) or expand
//   (i_code_byte to o_pcm_out). The unused result field reads zero.
//   Output channel (o_out_valid / i_out_stall) carries one result transaction
//   per accepted input, in order.
//   The APB port sets law_select (0x0), mu_bias (0x4) and mu_max_magnitude (0x8);
//   write it only while no transaction is in flight.
//   An accepted sample is registered in the input stage and then in the result
//   stage, which presents it on the output. Throughput is one transaction per
//   cycle while the receiver does not stall, since the compress/expand logic
//   between the input register and the result register is combinational.
//   Reset (synchronous, active low) empties both stages and restores A-law,
//   bias 33 and clamp 8191. When the receiver stalls, the result holds and
//   the input stage keeps accepting until it is full too; from then on
//   o_in_stall follows i_out_stall in the same cycle.
`default_nettype none

module g711_companding_codec
    import g711c_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    // Configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [CfgAddrW-1:0]  paddr,
    input  wire logic [CfgDataW-1:0]  pwdata,
    output logic [CfgDataW-1:0]       prdata,
    output logic                      pready,

    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_action,
    input  wire logic signed [15:0]   i_pcm_sample,
    input  wire logic [7:0]           i_code_byte,

    // Output channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [7:0]                o_code_out,
    output logic signed [13:0]        o_pcm_out
);

    // Configuration registers.
    t_cfg        r_cfg;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    // Input stage.
    logic               r_s1_valid;
    logic               r_s1_action;
    logic signed [15:0] r_s1_pcm;
    logic [7:0]         r_s1_code;

    // Result stage.
    logic               r_out_valid;
    logic [7:0]         r_code_out;
    logic signed [13:0] r_pcm_out;

    logic               in_accept;
    logic               s2_adv;
    logic [7:0]         n_code_out;
    logic signed [13:0] n_pcm_out;

    // Register write decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    // Configuration write; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.law_select       <= LAW_A;
            r_cfg.mu_bias          <= MU_BIAS_RESET;
            r_cfg.mu_max_magnitude <= MU_MAX_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LAW_SELECT:       r_cfg.law_select       <= pwdata[0];
                REG_MU_BIAS:          r_cfg.mu_bias          <= pwdata[7:0];
                REG_MU_MAX_MAGNITUDE: r_cfg.mu_max_magnitude <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_LAW_SELECT:       prdata = CfgDataW'(r_cfg.law_select);
            REG_MU_BIAS:          prdata = CfgDataW'(r_cfg.mu_bias);
            REG_MU_MAX_MAGNITUDE: prdata = CfgDataW'(r_cfg.mu_max_magnitude);
            default:              prdata = '0;
        endcase
    end

    // Flow control: the result stage moves when empty or not stalled,
    // the input stage takes a transaction when empty or moving on.
    assign s2_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s2_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Input stage payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= i_action;
            r_s1_pcm    <= i_pcm_sample;
            r_s1_code   <= i_code_byte;
        end
    end

    // Compress/expand logic between the two stages.
    g711c_datapath u_datapath (
        .i_cfg        (r_cfg),
        .i_action     (r_s1_action),
        .i_pcm_sample (r_s1_pcm),
        .i_code_byte  (r_s1_code),
        .o_code_out   (n_code_out),
        .o_pcm_out    (n_pcm_out)
    );

    // Result stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Result stage payload.
    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_code_out <= n_code_out;
            r_pcm_out  <= n_pcm_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code_out  = r_code_out;
    assign o_pcm_out   = r_pcm_out;

    // Checks on the pipeline and the result fields.
    `include "g711_companding_codec_assert.svh"

    `G711C_ASSERT_NEXT(a_accept_fills_s1, in_accept, r_s1_valid, "accepted transaction lost at input stage")
    `G711C_ASSERT_NEXT(a_s1_to_empty_out, r_s1_valid && !r_out_valid, r_out_valid, "input stage did not move into empty result stage")
    `G711C_ASSERT_NOW(a_one_field_used, r_out_valid, (r_pcm_out == 14'sd0) || (r_code_out == 8'd0), "both result fields nonzero")
    `G711C_ASSERT_NOW(a_pcm_range, r_out_valid, (r_pcm_out <= 14'sd8064) && (r_pcm_out >= -14'sd8064), "expanded sample out of range")

endmodule

`default_nettype wire

@@ rtl/core/g711c_datapath.sv @@
// Combinational compress/expand datapath for one sample of the G.711 codec.
// Depends on g711c_pkg for the configuration struct and the leading-one search.
`default_nettype none

module g711c_datapath
    import g711c_pkg::*;
(
    input  var t_cfg               i_cfg,
    input  wire logic              i_action,
    input  wire logic signed [15:0] i_pcm_sample,
    input  wire logic [7:0]        i_code_byte,
    output logic [7:0]             o_code_out,
    output logic signed [13:0]     o_pcm_out
);

    // Sign and magnitude of the linear sample.
    logic        neg;
    logic        sign_bit;
    logic [15:0] mag;

    // A-law compression.
    logic        a_sat;
    logic [12:0] a_mag;
    logic [3:0]  a_lead;
    logic [2:0]  a_seg;
    logic [3:0]  a_nib;
    logic [2:0]  a_high;
    logic [7:0]  a_code;

    // Mu-law compression.
    logic [16:0] mu_sum;
    logic [12:0] mu_mag;
    logic [3:0]  mu_lead;
    logic [3:0]  mu_seg;
    logic [3:0]  mu_nib;
    logic [2:0]  mu_high;
    logic [7:0]  mu_code;

    // Expansion.
    logic [2:0]  a_ex;
    logic [3:0]  a_man;
    logic [12:0] a_exp;
    logic [7:0]  mu_inv;
    logic [12:0] mu_exp;
    logic [12:0] exp_mag;
    logic [13:0] exp_pcm;

    // The most negative sample gives 0x8000, which still fits as an unsigned magnitude.
    always_comb begin
        neg      = i_pcm_sample[15];
        sign_bit = ~neg;
        mag      = neg ? (16'd0 - i_pcm_sample) : i_pcm_sample;
    end

    // A-law: saturate large magnitudes, else segment from the leading one.
    always_comb begin
        a_sat  = |mag[15:12];
        a_mag  = {1'b0, mag[11:0]};
        a_lead = lead_pos(a_mag);
        a_seg  = (a_mag < 13'd64) ? 3'd1 : 3'(a_lead - 4'd4);
        a_nib  = 4'(a_mag >> a_seg);
        a_high = (a_mag >= 13'd32) ? a_seg : 3'd0;
        a_code = a_sat ? {sign_bit, 7'h7F} : {sign_bit, a_high, a_nib};
    end

    // Mu-law: add the bias, clamp, segment and invert the low seven bits.
    always_comb begin
        mu_sum  = 17'(mag) + 17'(i_cfg.mu_bias);
        mu_mag  = (mu_sum > 17'(i_cfg.mu_max_magnitude)) ? i_cfg.mu_max_magnitude
                                                         : mu_sum[12:0];
        mu_lead = lead_pos(mu_mag);
        mu_seg  = (mu_mag < 13'd64) ? 4'd1 : (mu_lead - 4'd4);
        mu_nib  = 4'(mu_mag >> mu_seg);
        mu_high = 3'(mu_seg - 4'd1);
        mu_code = {sign_bit, ~{mu_high, mu_nib}};
    end

    // Expansion: rebuild the magnitude from exponent and mantissa, then apply the sign.
    always_comb begin
        a_ex    = i_code_byte[6:4];
        a_man   = i_code_byte[3:0];
        a_exp   = (a_ex == 3'd0) ? 13'({a_man, 1'b1})
                                 : (13'({1'b1, a_man, 1'b1}) << (a_ex - 3'd1));
        mu_inv  = ~i_code_byte;
        mu_exp  = 13'({1'b1, mu_inv[3:0], 1'b1}) << mu_inv[6:4];
        exp_mag = (i_cfg.law_select == LAW_MU) ? mu_exp : a_exp;
        exp_pcm = i_code_byte[7] ? {1'b0, exp_mag} : (14'd0 - {1'b0, exp_mag});
    end

    // The field that does not belong to the requested action is zero.
    always_comb begin
        if (i_action == ACT_EXPAND) begin
            o_code_out = 8'd0;
            o_pcm_out  = exp_pcm;
        end else begin
            o_code_out = (i_cfg.law_select == LAW_MU) ? mu_code : a_code;
            o_pcm_out  = 14'sd0;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_g711_companding_codec.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the G.711 A-law / mu-law companding codec.
// Depends on g711c_pkg and g711_companding_codec; predicts each result in a scoreboard class.

module tb_g711_companding_codec
    import g711c_pkg::*;
;

    localparam int WatchdogLimit = 1000;
    localparam int ItemsPerSetting = 250;
    localparam int NumSettings = 8;

    // One expected result transaction.
    typedef struct packed {
        logic [7:0]         code;
        logic signed [13:0] pcm;
    } t_codec_result;

    // Scoreboard: keeps a copy of the registers, predicts results, checks them in order.
    class companding_scoreboard;
        logic          law;
        logic [7:0]    bias;
        logic [12:0]   max_mag;
        t_codec_result expected_q[$];
        int unsigned   n_errors;
        int unsigned   n_compress;
        int unsigned   n_expand;
        int unsigned   n_checked;

        function new();
            law = LAW_A;
            bias = MU_BIAS_RESET;
            max_mag = MU_MAX_RESET;
            n_errors = 0;
            n_compress = 0;
            n_expand = 0;
            n_checked = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_LAW_SELECT: law = value[0];
                REG_MU_BIAS: bias = value[7:0];
                REG_MU_MAX_MAGNITUDE: max_mag = value[12:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Index of the highest set bit; callers only pass nonzero values.
        function int msb_index(logic [17:0] v);
            int p;
            p = 0;
            for (int i = 0; i < 18; i++) begin
                if (v[i]) begin
                    p = i;
                end
            end
            return p;
        endfunction

        // A-law: large magnitudes saturate, the low segment has no implied one.
        function logic [7:0] compress_alaw(logic sgn, logic [17:0] mag);
            int       seg;
            logic [3:0] nib;
            logic [2:0] high;
            if (mag >= 18'd4096) begin
                return {sgn, 7'h7F};
            end
            seg = (mag < 18'd64) ? 1 : msb_index(mag) - 4;
            nib = 4'(mag >> seg);
            high = (mag >= 18'd32) ? 3'(seg) : 3'd0;
            return {sgn, high, nib};
        endfunction

        // Mu-law: bias is added at full width and then clamped, so the
        // magnitude never reaches 8192 and the segment tops out at 8.
        function logic [7:0] compress_mulaw(logic sgn, logic [17:0] mag);
            logic [17:0] biased;
            int          seg;
            logic [3:0]  nib;
            logic [2:0]  high;
            biased = mag + {10'd0, bias};
            if (biased > {5'd0, max_mag}) begin
                biased = {5'd0, max_mag};
            end
            seg = (biased < 18'd64) ? 1 : msb_index(biased) - 4;
            nib = 4'(biased >> seg);
            high = 3'(seg - 1);
            return {sgn, ~{high, nib}};
        endfunction

        function logic signed [13:0] expand_alaw(logic [7:0] code);
            logic [2:0]  ex;
            logic [13:0] mag;
            ex = code[6:4];
            if (ex == 3'd0) begin
                mag = 14'({code[3:0], 1'b1});
            end else begin
                mag = 14'({1'b1, code[3:0], 1'b1}) << (ex - 3'd1);
            end
            return code[7] ? mag : -mag;
        endfunction

        function logic signed [13:0] expand_mulaw(logic [7:0] code);
            logic [7:0]  inv;
            logic [13:0] mag;
            inv = ~code;
            mag = 14'({1'b1, inv[3:0], 1'b1}) << inv[6:4];
            return code[7] ? mag : -mag;
        endfunction

        // Work out the result of one accepted input and queue it.
        function void note_input(logic act, logic signed [15:0] pcm, logic [7:0] code);
            t_codec_result res;
            logic          neg;
            logic [17:0]   mag;
            res = '0;
            if (act == ACT_COMPRESS) begin
                // The most negative sample has magnitude 32768; zero counts as positive.
                neg = pcm[15];
                mag = neg ? 18'h10000 - {2'b00, pcm} : {2'b00, pcm};
                res.code = (law == LAW_MU) ? compress_mulaw(!neg, mag)
                                           : compress_alaw(!neg, mag);
                n_compress++;
            end else begin
                res.pcm = (law == LAW_MU) ? expand_mulaw(code) : expand_alaw(code);
                n_expand++;
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            n_errors++;
        endtask

        // Compare one result transaction with the oldest expectation.
        task check_result(logic [7:0] code, logic signed [13:0] pcm);
            t_codec_result exp_res;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result code=%02h pcm=%0d", code, pcm));
            end else begin
                exp_res = expected_q.pop_front();
                n_checked++;
                if (code !== exp_res.code) begin
                    report_mismatch($sformatf("code_out %02h, expected %02h",
                                              code, exp_res.code));
                end
                if (pcm !== exp_res.pcm) begin
                    report_mismatch($sformatf("pcm_out %0d, expected %0d", pcm, exp_res.pcm));
                end
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CfgAddrW-1:0]   paddr;
    logic [CfgDataW-1:0]   pwdata;
    logic [CfgDataW-1:0]   prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_action;
    logic signed [15:0]    i_pcm_sample;
    logic [7:0]            i_code_byte;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_code_out;
    logic signed [13:0]    o_pcm_out;

    int unsigned           src_idle_pct = 32;
    int unsigned           sink_stall_pct = 60;
    int unsigned           quiet_cycles = 0;
    companding_scoreboard  sb = new();

    g711_companding_codec i_dut (.*);

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Check every accepted result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_code_out, o_pcm_out);
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WatchdogLimit) begin
                $display("Watchdog expired after %0d quiet cycles", WatchdogLimit);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Send one input transaction; called and returns at a falling edge.
    task automatic push_sample(input logic act, input logic signed [15:0] pcm,
                               input logic [7:0] code);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_pcm_sample <= pcm;
        i_code_byte <= code;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(act, pcm, code);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected result has come back.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CfgAddrW'({idx, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drain, let the pipeline settle, then load all three registers.
    task automatic reconfigure(input logic law, input logic [7:0] bias,
                               input logic [12:0] max_mag);
        wait_for_results();
        repeat (3) @(negedge i_clk);
        write_register(REG_LAW_SELECT, {31'd0, law});
        write_register(REG_MU_BIAS, {24'd0, bias});
        write_register(REG_MU_MAX_MAGNITUDE, {19'd0, max_mag});
    endtask

    // Samples spread over all segments, with the edge values now and then.
    function automatic logic signed [15:0] rand_pcm();
        logic [15:0] mag;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 7))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return 16'sd0;
                3: return -16'sd1;
                4: return 16'sd4095;
                5: return -16'sd4096;
                6: return 16'sd63;
                default: return -16'sd32;
            endcase
        end
        mag = 16'($urandom()) >> $urandom_range(0, 15);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    initial begin
        logic        law_v;
        logic [7:0]  bias_v;
        logic [12:0] max_v;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_action = ACT_COMPRESS;
        i_pcm_sample = '0;
        i_code_byte = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: A-law with reset register values, segment edges and extremes.
        push_sample(ACT_COMPRESS, 16'sd0, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd1, 8'($urandom()));
        push_sample(ACT_COMPRESS, -16'sd1, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd31, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd32, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd63, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd64, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd4095, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd4096, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd32767, 8'($urandom()));
        push_sample(ACT_COMPRESS, -16'sd32768, 8'($urandom()));
        push_sample(ACT_EXPAND, 16'($urandom()), 8'h00);
        push_sample(ACT_EXPAND, 16'($urandom()), 8'h0F);
        push_sample(ACT_EXPAND, 16'($urandom()), 8'h70);
        push_sample(ACT_EXPAND, 16'($urandom()), 8'h7F);
        push_sample(ACT_EXPAND, 16'($urandom()), 8'h80);
        push_sample(ACT_EXPAND, 16'($urandom()), 8'hFF);

        // Directed: mu-law with the largest bias, so big samples overflow and clamp.
        reconfigure(LAW_MU, 8'd255, 13'd8191);
        push_sample(ACT_COMPRESS, 16'sd32767, 8'($urandom()));
        push_sample(ACT_COMPRESS, -16'sd32768, 8'($urandom()));
        push_sample(ACT_COMPRESS, 16'sd0, 8'($urandom()));
        push_sample(ACT_EXPAND, 16'($urandom()), 8'h00);
        push_sample(ACT_EXPAND, 16'($urandom()), 8'hFF);
        push_sample(ACT_EXPAND, 16'($urandom()), 8'h80);

        // Directed: clamp of zero forces every code to the bottom segment.
        reconfigure(LAW_MU, 8'd0, 13'd0);
        push_sample(ACT_COMPRESS, 16'sd100, 8'($urandom()));

        // Random transactions under a series of register settings.
        for (int setting = 0; setting < NumSettings; setting++) begin
            case (setting)
                0: begin law_v = LAW_A; bias_v = MU_BIAS_RESET; max_v = MU_MAX_RESET; end
                1: begin law_v = LAW_MU; bias_v = MU_BIAS_RESET; max_v = MU_MAX_RESET; end
                2: begin law_v = LAW_MU; bias_v = 8'd255; max_v = 13'd8191; end
                3: begin law_v = LAW_MU; bias_v = 8'd0; max_v = 13'd0; end
                4: begin law_v = LAW_A; bias_v = 8'd255; max_v = 13'd0; end
                5: begin
                    law_v = LAW_MU;
                    bias_v = 8'($urandom());
                    max_v = 13'($urandom_range(0, 8191));
                end
                6: begin law_v = LAW_MU; bias_v = 8'd0; max_v = 13'd8191; end
                default: begin
                    law_v = 1'($urandom_range(0, 1));
                    bias_v = 8'($urandom());
                    max_v = 13'($urandom_range(0, 8191));
                end
            endcase
            reconfigure(law_v, bias_v, max_v);
            src_idle_pct = (setting < 3) ? 32 : (setting < 6) ? 60 : 0;
            sink_stall_pct = (setting < 3) ? 60 : (setting < 6) ? 32 : 0;
            for (int n = 0; n < ItemsPerSetting; n++) begin
                if ($urandom_range(0, 199) == 0) begin
                    wait_for_results();
                end
                push_sample(1'($urandom_range(0, 1)), rand_pcm(), 8'($urandom()));
            end
        end

        // Drain and let any stray result show up.
        wait_for_results();
        repeat (8) @(negedge i_clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end

        $display("Ran %0d compress and %0d expand transactions, %0d results checked,",
                 sb.n_compress, sb.n_expand, sb.n_checked);
        $display("across A-law and mu-law settings including bias and clamp extremes.");
        if (sb.n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/g711c_pkg.sv
rtl/core/g711c_datapath.sv
rtl/core/g711_companding_codec.sv
dv/tb_g711_companding_codec.sv
